### hw/rtl/pfld_pkg.sv
// ---------------------------------------------------------------------------
// pfld_pkg: shared types and constants of the paged line drawer
// Opcodes, framebuffer layout constants and the stepper control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pfld_pkg;

   // opcodes carried in a request word
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // framebuffer layout: 8 rows per page byte
   localparam int          ROWS_PER_PAGE = 8;
   localparam int          PAGE_SHIFT    = 3;
   localparam logic [2:0]  ROW_BIT_MASK  = 3'd7;
   localparam logic [7:0]  CLEAR_VALUE   = 8'h00;

   // field widths fixed by the request word
   localparam int X_W   = 7;
   localparam int YIN_W = 6;
   localparam int IDX_W = 10;

   // stepper datapath widths: y wanders -127..191, error term stays within +-16k
   localparam int Y_W   = 9;
   localparam int ERR_W = 16;

   // control into the Bresenham stepper
   typedef struct packed {
      logic load;
      logic advance;
   } step_ctl_type;

   // current pixel out of the stepper
   typedef struct packed {
      logic [X_W-1:0]        x;
      logic signed [Y_W-1:0] y;
      logic                  last;
   } pixel_type;

endpackage

`default_nettype wire

### hw/rtl/pfld_chan_if.sv
// ---------------------------------------------------------------------------
// pfld_chan_if: request and response channels of the paged line drawer
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ---------------------------------------------------------------------------
`default_nettype none

interface pfld_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [pfld_pkg::X_W-1:0]      start_x;
   logic [pfld_pkg::YIN_W-1:0]    start_y;
   logic [pfld_pkg::X_W-1:0]      end_x;
   logic [pfld_pkg::YIN_W-1:0]    end_y;
   logic [pfld_pkg::IDX_W-1:0]    byte_index;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, byte_index,
                   input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, byte_index,
                   output ready);
endinterface

interface pfld_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] read_data;

   modport source (output valid, status, read_data, input ready);
   modport sink   (input valid, status, read_data, output ready);
endinterface

`default_nettype wire

### hw/rtl/page_framebuffer_line_drawer_core.sv
// ---------------------------------------------------------------------------
// page_framebuffer_line_drawer_core: line drawer over a paged mono framebuffer
// Draws Bresenham lines, reads bytes and clears a COLUMNS x PAGES byte store.
// ---------------------------------------------------------------------------
// The store holds PAGES pages of COLUMNS bytes; byte page*COLUMNS+x carries
// rows page*8..page*8+7 of column x, bit y%8 being row y. Every request word
// gives exactly one response word. Only one request is in work at a time;
// req_port.ready is high only while the sequencer is idle, but a new request
// is taken while the previous response still waits in the output register.
// Per opcode, over the read-modify-write loop on the dual-port store:
//   draw:  reads and ORs one page byte per column, lower x to higher x
//   vertical line (start_x == end_x): status 1, nothing drawn
//   read:  an index at or past COLUMNS*PAGES returns zero
//   clear: writes every byte of the store, one byte per cycle
//   other opcodes: all-zero response
// After reset a clearing pass over all COLUMNS*PAGES bytes (1024 by default)
// runs with ready low before the first request is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_line_drawer_core #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   pfld_req_if.sink   req_port,
   pfld_rsp_if.source rsp_port
);

   localparam int STORE_SIZE = COLUMNS * PAGES;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int YW         = pfld_pkg::Y_W;

   localparam logic [8:0]        COL_LIM   = 9'(COLUMNS);
   localparam logic [7:0]        ROW_LIM   = 8'(PAGES * pfld_pkg::ROWS_PER_PAGE);
   localparam logic [12:0]       STORE_LIM = 13'(STORE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_PIX_RD = 3'd2;
   localparam logic [2:0] ST_PIX_WR = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_rsp_ff, clr_rsp_in;   // clear came from a request
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              status_ff, status_in;
   logic              hit_ff, hit_in;           // read word lies inside the store
   logic [ADDR_W-1:0] addr_ff, addr_in;         // pixel byte under read-modify-write
   logic [7:0]        mask_ff, mask_in;
   logic              vis_ff, vis_in;

   logic                   req_accept, rsp_load;
   pfld_pkg::step_ctl_type step_ctl;
   pfld_pkg::pixel_type    pix;

   logic              pix_vis;
   logic [15:0]       pix_idx, req_idx;
   logic [ADDR_W-1:0] pix_addr;
   logic              req_hit;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   pfld_stepper u_stepper (
      .clock   (clock),
      .ctl     (step_ctl),
      .start_x (req_port.start_x),
      .start_y (req_port.start_y),
      .end_x   (req_port.end_x),
      .end_y   (req_port.end_y),
      .pix     (pix)
   );

   pfld_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;

   // output register frees the sequencer once the response slot is open
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_port.ready);

   // pixel visibility and byte address; off-screen pixels (negative y too) skip the write
   always_comb begin
      pix_vis  = !pix.y[YW-1] && (pix.y[7:0] < ROW_LIM) && ({2'b00, pix.x} < COL_LIM);
      pix_idx  = 16'(pix.y[YW-2:pfld_pkg::PAGE_SHIFT]) * 16'(COLUMNS) + 16'(pix.x);
      pix_addr = pix_idx[ADDR_W-1:0];
      req_idx  = 16'(req_port.byte_index);
      req_hit  = ({3'b000, req_port.byte_index} < STORE_LIM);
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      vis_in        = vis_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      step_ctl      = '0;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = ram_rdata | mask_ff;
      ram_re        = 1'b0;
      ram_raddr     = req_idx[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in = 1'b0;
               hit_in    = 1'b0;
               case (req_port.opcode)
                  pfld_pkg::OP_DRAW: begin
                     if (req_port.start_x == req_port.end_x) begin
                        status_in = 1'b1;
                        state_in  = ST_FINISH;
                     end else begin
                        step_ctl.load = 1'b1;
                        state_in      = ST_PIX_RD;
                     end
                  end
                  pfld_pkg::OP_READ: begin
                     // data shows on the RAM output in the finish cycle
                     hit_in   = req_hit;
                     ram_re   = req_hit;
                     state_in = ST_FINISH;
                  end
                  pfld_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = pfld_pkg::CLEAR_VALUE;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_PIX_RD: begin
            ram_re    = 1'b1;
            ram_raddr = pix_addr;
            addr_in   = pix_addr;
            mask_in   = 8'(1) << (pix.y[2:0] & pfld_pkg::ROW_BIT_MASK);
            vis_in    = pix_vis;
            state_in  = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            // OR the pixel into the byte read last cycle, then step a column
            ram_we           = vis_ff;
            step_ctl.advance = 1'b1;
            state_in         = pix.last ? ST_FINISH : ST_PIX_RD;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_status_in = status_ff;
               rsp_data_in   = hit_ff ? ram_rdata : 8'h00;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_port.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      vis_ff        <= vis_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.status    = rsp_status_ff;
   assign rsp_port.read_data = rsp_data_ff;

   // store writes come only from the clearing pass or the pixel write slot
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_PIX_WR))
      else $error("store written outside clear or pixel write");

   // reset always starts a full clearing pass from address zero
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && clr_cnt_ff == '0))
      else $error("reset did not start the clearing pass");

   // an accepted word always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after accepting a word");

   // a response is loaded only when the slot was free or being drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_port.ready))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

### hw/rtl/pfld_ram.sv
// ---------------------------------------------------------------------------
// pfld_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
`default_nettype none

module pfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pfld_stepper.sv
// ---------------------------------------------------------------------------
// pfld_stepper: Bresenham column stepper
// Orders endpoints by x on load, then walks one column per advance.
// ---------------------------------------------------------------------------
`default_nettype none

module pfld_stepper (
   input  wire logic                          clock,
   input  wire pfld_pkg::step_ctl_type        ctl,
   input  wire logic [pfld_pkg::X_W-1:0]      start_x,
   input  wire logic [pfld_pkg::YIN_W-1:0]    start_y,
   input  wire logic [pfld_pkg::X_W-1:0]      end_x,
   input  wire logic [pfld_pkg::YIN_W-1:0]    end_y,
   output pfld_pkg::pixel_type                pix
);

   localparam int XW = pfld_pkg::X_W;
   localparam int YI = pfld_pkg::YIN_W;
   localparam int YW = pfld_pkg::Y_W;
   localparam int EW = pfld_pkg::ERR_W;

   logic                 swap;
   logic [XW-1:0]        x0, x1, dx;
   logic [YI-1:0]        y0, y1, dy_abs;
   logic signed [YI:0]   dy_s;
   logic signed [EW-1:0] two_dy, two_dx, dx_ext, err_load, inc_pos;
   logic                 err_ge;

   logic [XW-1:0]        x_ff, x_in, xend_ff, xend_in;
   logic signed [YW-1:0] y_ff, y_in;
   logic signed [EW-1:0] err_ff, err_in, inc_pos_ff, inc_pos_in, inc_neg_ff, inc_neg_in;
   logic                 dir_neg_ff, dir_neg_in;

   always_comb begin
      // endpoint ordering and setup terms
      swap     = start_x > end_x;
      x0       = swap ? end_x   : start_x;
      x1       = swap ? start_x : end_x;
      y0       = swap ? end_y   : start_y;
      y1       = swap ? start_y : end_y;
      dx       = x1 - x0;
      dy_s     = $signed({1'b0, y1}) - $signed({1'b0, y0});
      dy_abs   = dy_s[YI] ? YI'(-dy_s) : dy_s[YI-1:0];
      two_dy   = $signed({{(EW-YI-1){1'b0}}, dy_abs, 1'b0});
      two_dx   = $signed({{(EW-XW-1){1'b0}}, dx, 1'b0});
      dx_ext   = $signed({{(EW-XW){1'b0}}, dx});
      err_load = two_dy - dx_ext;
      inc_pos  = two_dy - two_dx;
      err_ge   = !err_ff[EW-1];

      x_in       = x_ff;
      xend_in    = xend_ff;
      y_in       = y_ff;
      err_in     = err_ff;
      inc_pos_in = inc_pos_ff;
      inc_neg_in = inc_neg_ff;
      dir_neg_in = dir_neg_ff;

      if (ctl.load) begin
         x_in       = x0;
         xend_in    = x1;
         y_in       = $signed({{(YW-YI){1'b0}}, y0});
         err_in     = err_load;
         inc_pos_in = inc_pos;
         inc_neg_in = two_dy;
         dir_neg_in = dy_s[YI];
      end else if (ctl.advance) begin
         x_in   = x_ff + XW'(1);
         // single error adder, operand picked by the sign of the error term
         err_in = err_ff + (err_ge ? inc_pos_ff : inc_neg_ff);
         if (err_ge) begin
            y_in = dir_neg_ff ? y_ff - YW'(1) : y_ff + YW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      xend_ff    <= xend_in;
      y_ff       <= y_in;
      err_ff     <= err_in;
      inc_pos_ff <= inc_pos_in;
      inc_neg_ff <= inc_neg_in;
      dir_neg_ff <= dir_neg_in;
   end

   assign pix.x    = x_ff;
   assign pix.y    = y_ff;
   assign pix.last = (x_ff == xend_ff);

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the paged framebuffer line drawer
// Drives draw, read, clear and unused-opcode words with random gaps and
// back-pressure. It keeps its own copy of the framebuffer and checks each
// response word against the oldest predicted one.
// ---------------------------------------------------------------------------

module tb_top;

   // request field widths
   localparam int X_W   = pfld_pkg::X_W;
   localparam int YIN_W = pfld_pkg::YIN_W;
   localparam int IDX_W = pfld_pkg::IDX_W;

   // framebuffer geometry, matching the core's default parameters
   localparam int FB_COLUMNS = 128;
   localparam int FB_PAGES   = 8;
   localparam int FB_ROWS    = FB_PAGES * pfld_pkg::ROWS_PER_PAGE;
   localparam int FB_BYTES   = FB_COLUMNS * FB_PAGES;

   // opcode 3 has no name in the package; the core must answer with zeros
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Watchdog limit on cycles without any handshake. The longest legal quiet
   // stretch is a clear or the clearing pass after reset, plus a long response
   // stall. Several times over.
   localparam int QUIET_LIMIT = 8000;
   // cycles allowed after the last response before the verdict
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 1250;

   typedef struct {
      logic       status;
      logic [7:0] read_data;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfld_req_if req_bus ();
   pfld_rsp_if rsp_bus ();

   page_framebuffer_line_drawer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bench copy of the framebuffer and the words the core still owes us
   logic [7:0]   pixel_bytes [FB_BYTES];
   rsp_word_type owed_words [$];
   int           mismatch_count = 0;
   bit           no_gaps = 1'b0;   // sender runs back to back while set
   int           recent_byte = 0;  // byte touched by a recent draw, read back often

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // OR one pixel into its page byte; anything off the screen is dropped
   function automatic void set_pixel(input int x, input int y);
      int idx;
      if (x < 0 || y < 0 || x >= FB_COLUMNS || y >= FB_ROWS) return;
      idx = (y >> pfld_pkg::PAGE_SHIFT) * FB_COLUMNS + x;
      pixel_bytes[idx][y % pfld_pkg::ROWS_PER_PAGE] = 1'b1;
   endfunction

   // Bresenham walk, one pixel per column, y steps at most one row toward
   // the far endpoint. Returns the status bit: 1 for a vertical line.
   function automatic logic rasterize_line(input int x0, input int y0,
                                           input int x1, input int y1);
      int t;
      int dx;
      int dy;
      int dir;
      int y;
      int err;
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      if (dx == 0) return 1'b1;
      dy = y1 - y0;
      dir = 1;
      if (dy < 0) begin
         dir = -1;
         dy = -dy;
      end
      y = y0;
      err = 2 * dy - dx;
      for (int i = 0; i <= dx; i++) begin
         set_pixel(x0 + i, y);
         if (err >= 0) begin
            y += dir;
            err += 2 * dy - 2 * dx;
         end else begin
            err += 2 * dy;
         end
      end
      return 1'b0;
   endfunction

   function automatic void wipe_frame();
      foreach (pixel_bytes[i]) pixel_bytes[i] = pfld_pkg::CLEAR_VALUE;
   endfunction

   // apply one accepted request word to the bench frame, return its response
   function automatic rsp_word_type predict_word(input logic [1:0] op,
                                                 input logic [X_W-1:0] sx,
                                                 input logic [YIN_W-1:0] sy,
                                                 input logic [X_W-1:0] ex,
                                                 input logic [YIN_W-1:0] ey,
                                                 input logic [IDX_W-1:0] idx);
      rsp_word_type w;
      w.status = 1'b0;
      w.read_data = 8'h00;
      case (op)
         pfld_pkg::OP_DRAW: begin
            w.status = rasterize_line(int'(sx), int'(sy), int'(ex), int'(ey));
         end
         pfld_pkg::OP_READ: begin
            if (int'(idx) < FB_BYTES) w.read_data = pixel_bytes[idx];
         end
         pfld_pkg::OP_CLEAR: begin
            wipe_frame();
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Request side: one word per call, driven at the falling edge.
   // valid stays high on return so back-to-back words keep it asserted.
   // ------------------------------------------------------------------------
   task automatic push_request(input logic [1:0] op,
                               input logic [X_W-1:0] sx,
                               input logic [YIN_W-1:0] sy,
                               input logic [X_W-1:0] ex,
                               input logic [YIN_W-1:0] ey,
                               input logic [IDX_W-1:0] idx);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.opcode     = op;
      req_bus.start_x    = sx;
      req_bus.start_y    = sy;
      req_bus.end_x      = ex;
      req_bus.end_y      = ey;
      req_bus.byte_index = idx;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      // accepted on this edge; the core handles one word at a time, so the
      // bench frame advances in acceptance order
      owed_words.push_back(predict_word(op, sx, sy, ex, ey, idx));
   endtask

   task automatic push_draw(input int sx, input int sy, input int ex, input int ey);
      push_request(pfld_pkg::OP_DRAW, X_W'(sx), YIN_W'(sy), X_W'(ex), YIN_W'(ey),
                   IDX_W'($urandom()));
   endtask

   task automatic push_read(input int idx);
      push_request(pfld_pkg::OP_READ, X_W'($urandom()), YIN_W'($urandom()),
                   X_W'($urandom()), YIN_W'($urandom()), IDX_W'(idx));
   endtask

   // ------------------------------------------------------------------------
   // Response side: ready toggles at the falling edge. Short ready bursts
   // with random stalls, now and then a long stretch with no stall at all.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacer
      int burst;
      int stall;
      forever begin
         burst = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 20);
         rsp_bus.ready = 1'b1;
         repeat (burst) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: every accepted word against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_checker
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected response word status=%0b read_data=%02h",
                     $time, rsp_bus.status, rsp_bus.read_data);
            mismatch_count++;
         end else begin
            want = owed_words.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status mismatch, expected %0b actual %0b",
                        $time, want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %02h actual %02h",
                        $time, want.read_data, rsp_bus.read_data);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too many cycles in a row without a handshake on either side
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles, %0d words outstanding",
               $time, QUIET_LIMIT, owed_words.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // store must read as zero once the clearing pass after reset is done
   task automatic test_power_up_reads();
      push_read(0);
      push_read(FB_BYTES - 1);
   endtask

   // edge geometry: full-width lines, swapped endpoints, steep both ways,
   // vertical reject, one-column step
   task automatic test_line_shapes();
      push_draw(0, 63, 127, 63);     // bottom row, full width
      push_draw(0, 0, 127, 63);      // corner to corner, shallow
      push_draw(127, 0, 0, 63);      // endpoints swapped, y descends after swap
      push_draw(10, 0, 12, 63);      // steep: one row per column
      push_draw(22, 63, 20, 0);      // steep, swapped
      push_draw(5, 10, 5, 40);       // vertical, rejected
      push_draw(1, 1, 2, 1);         // two pixels
      push_read(0);
      push_read(FB_BYTES - 1);
      push_read(7 * FB_COLUMNS);
      push_read(11);
      push_read(1 * FB_COLUMNS + 21);
      push_read(5);                  // column of the vertical line, page 0; page 1 is read next
      push_read(1 * FB_COLUMNS + 5);
   endtask

   // unused opcode with every field at its top, then clear and read back
   task automatic test_opcodes_and_clear();
      push_request(OP_UNUSED, '1, '1, '1, '1, '1);
      push_request(pfld_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
      push_read(FB_BYTES - 1);
      push_read(0);
   endtask

   task automatic test_random_traffic();
      int r;
      int sx;
      int sy;
      int ex;
      int ey;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 45) begin
            sx = $urandom_range(0, 127);
            sy = $urandom_range(0, 63);
            ey = $urandom_range(0, 63);
            r = $urandom_range(0, 99);
            if (r < 60) ex = $urandom_range(0, 127);
            else if (r < 85) ex = sx + $urandom_range(0, 16) - 8;
            else if (r < 95) ex = sx;
            else begin
               ex = $urandom_range(0, 127);
               ey = sy;
            end
            if (ex < 0) ex = 0;
            if (ex > 127) ex = 127;
            // remember one endpoint so reads hit drawn bytes often
            if ($urandom_range(0, 1) == 1)
               recent_byte = (sy >> pfld_pkg::PAGE_SHIFT) * FB_COLUMNS + sx;
            else
               recent_byte = (ey >> pfld_pkg::PAGE_SHIFT) * FB_COLUMNS + ex;
            push_draw(sx, sy, ex, ey);
         end else if (r < 92) begin
            push_read($urandom_range(0, 1) ? recent_byte : $urandom_range(0, FB_BYTES - 1));
         end else if (r < 95) begin
            push_request(pfld_pkg::OP_CLEAR, X_W'($urandom()), YIN_W'($urandom()),
                         X_W'($urandom()), YIN_W'($urandom()), IDX_W'($urandom()));
         end else begin
            push_request(OP_UNUSED, X_W'($urandom()), YIN_W'($urandom()), X_W'($urandom()),
                         YIN_W'($urandom()), IDX_W'($urandom()));
         end
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid      = 1'b0;
      req_bus.opcode     = pfld_pkg::OP_DRAW;
      req_bus.start_x    = '0;
      req_bus.start_y    = '0;
      req_bus.end_x      = '0;
      req_bus.end_y      = '0;
      req_bus.byte_index = '0;
      wipe_frame();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // the first request waits out the clearing pass on ready
      test_power_up_reads();
      test_line_shapes();
      test_opcodes_and_clear();
      test_random_traffic();

      @(negedge clock);
      req_bus.valid = 1'b0;

      while (owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
